@@ rtl/quicksort_array_sorter_assert.svh @@
// Assertion macros for the quicksort array sorter
`ifndef QUICKSORT_ARRAY_SORTER_ASSERT_SVH
`define QUICKSORT_ARRAY_SORTER_ASSERT_SVH
`define QS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/qsort_pkg.sv @@
// Package: shared types and constants for the quicksort array sorter
package qsort_pkg;
    localparam int MaxItemsDefault = 64;
    localparam int WordBitsDefault = 32;
    localparam logic [15:0] LfsrSeed = 16'hACE1;
    localparam logic [15:0] LfsrTaps = 16'hB400;

    typedef struct packed {
        logic [WordBitsDefault-1:0] value;
        logic                       last_item;
    } in_item_t;

    typedef struct packed {
        logic [WordBitsDefault-1:0] sorted_value;
        logic                       last_result;
        logic                       overflow;
    } out_item_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] n;
        n = {1'b0, s[15:1]};
        if (s[0])
        begin
            n = n ^ LfsrTaps;
        end
        return n;
    endfunction
endpackage

@@ rtl/quicksort_array_sorter.sv @@
// Top level: quicksort array sorter with Lomuto partitioning
// Usage:
//   Input channel (valid/ready, payload in_item_t): one word per request,
//   last_item on the final word of a set. Words beyond MAX_ITEMS are dropped
//   and every result of that burst carries overflow.
//   Output channel (valid/ready, out_item_t): the set in ascending unsigned
//   order, last_result on the greatest word.
//   Loading accepts one word per cycle. After the marked word the sort runs on
//   the item memory (one write port, one read port): each compare is a read,
//   then a decision; each swap adds two reads and two writes; and each
//   partition adds a pivot swap, a closing swap and bookkeeping.
//   Unload takes one read per word; a stall holds the output register and
//   the sequencer. No new words are taken during sort or unload; loading
//   resumes while the greatest word still waits in the output register.
//   Reset clears counts, stack pointer, overflow flag and loads the LFSR
//   seed; the memory needs no clearing.
module quicksort_array_sorter
    import qsort_pkg::*;
#(
    parameter int MAX_ITEMS = MaxItemsDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    localparam int WORD_BITS = WordBitsDefault;
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SD = AW + 1;
    localparam int SPW = $clog2(SD + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_PIV   = 4'd2;
    localparam logic [3:0] S_SW1   = 4'd3;
    localparam logic [3:0] S_SW2   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_XW1   = 4'd7;
    localparam logic [3:0] S_XW2   = 4'd8;
    localparam logic [3:0] S_SPLIT = 4'd9;
    localparam logic [3:0] S_ORD   = 4'd10;
    localparam logic [3:0] S_ORDW  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_RD    = 4'd13;

    logic [3:0] state_reg;
    logic [CW-1:0] count_reg;
    logic overflow_reg;
    logic [15:0] lfsr_reg;
    logic [AW-1:0] lo_reg, hi_reg, place_reg, k_reg, swa_reg, swb_reg;
    logic [WORD_BITS-1:0] pivot_reg, wa_reg, wb_reg;
    logic [3:0] ret_reg;
    logic [AW-1:0] stk_lo [SD];
    logic [AW-1:0] stk_hi [SD];
    logic [SPW-1:0] sp_reg;
    logic [CW-1:0] oidx_reg;
    logic ovalid_reg;
    out_item_t oitem_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;
    logic [15:0] lfsr_n;
    logic [AW+15:0] prod;
    logic [AW:0] len;
    logic [AW-1:0] ridx, left, right;

    qsort_store #(.MAX_ITEMS(MAX_ITEMS), .WORD_BITS(WORD_BITS)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign lfsr_n = lfsr_step(lfsr_reg);
    assign len = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
    assign prod = (AW + 16)'(lfsr_n) * (AW + 16)'(len);
    assign ridx = lo_reg + prod[AW+15:16];
    assign left = place_reg - lo_reg;
    assign right = hi_reg - place_reg;

    assign in_ready = (state_reg == S_LOAD);
    assign out_valid = ovalid_reg;
    assign out_item = oitem_reg;

    always_comb
    begin
        we = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = in_item.value;
        raddr = k_reg;
        case (state_reg)
            S_LOAD:
            begin
                we = in_valid && (count_reg < CW'(MAX_ITEMS));
            end
            S_SW1:
            begin
                raddr = swa_reg;
            end
            S_PIV:
            begin
                raddr = swb_reg;
            end
            S_SW2:
            begin
                we = 1'b1;
                waddr = swa_reg;
                wdata = wb_reg;
            end
            S_XW2:
            begin
                we = 1'b1;
                waddr = swb_reg;
                wdata = wa_reg;
            end
            S_RD, S_OUT:
            begin
                raddr = oidx_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // swap sequence: S_SW1 reads a, S_PIV latches a/reads b, S_XW1 latches b,
    // S_SW2 writes a, S_XW2 writes b, then branches on ret_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            overflow_reg <= 1'b0;
            lfsr_reg <= LfsrSeed;
            sp_reg <= '0;
            ovalid_reg <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        if (count_reg < CW'(MAX_ITEMS))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (in_item.last_item)
                        begin
                            oidx_reg <= '0;
                            if (count_reg >= CW'(1))
                            begin
                                lo_reg <= '0;
                                hi_reg <= (count_reg < CW'(MAX_ITEMS)) ?
                                          count_reg[AW-1:0] : AW'(MAX_ITEMS - 1);
                                state_reg <= S_SPLIT;
                                sp_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        lo_reg <= stk_lo[sp_reg - 1'b1];
                        hi_reg <= stk_hi[sp_reg - 1'b1];
                        sp_reg <= sp_reg - 1'b1;
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        lfsr_reg <= lfsr_n;
                        swa_reg <= hi_reg;
                        swb_reg <= ridx;
                        k_reg <= hi_reg;
                        ret_reg <= S_ORD;
                        state_reg <= S_SW1;
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_SW1:
                begin
                    state_reg <= S_PIV;
                end
                S_PIV:
                begin
                    wa_reg <= rdata;
                    state_reg <= S_XW1;
                end
                S_XW1:
                begin
                    wb_reg <= rdata;
                    state_reg <= S_SW2;
                end
                S_SW2:
                begin
                    state_reg <= S_XW2;
                end
                S_XW2:
                begin
                    if (ret_reg == S_ORD)
                    begin
                        pivot_reg <= wb_reg;
                        place_reg <= lo_reg;
                        k_reg <= lo_reg;
                        state_reg <= S_SCAN;
                    end
                    else if (ret_reg == S_SCAN)
                    begin
                        place_reg <= place_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_ORDW;
                    end
                end
                S_SCAN:
                begin
                    if (k_reg == hi_reg)
                    begin
                        swa_reg <= place_reg;
                        swb_reg <= hi_reg;
                        k_reg <= place_reg;
                        ret_reg <= S_ORDW;
                        state_reg <= S_SW1;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (rdata <= pivot_reg)
                    begin
                        if (place_reg == k_reg)
                        begin
                            place_reg <= place_reg + 1'b1;
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            swa_reg <= place_reg;
                            swb_reg <= k_reg;
                            ret_reg <= S_SCAN;
                            state_reg <= S_SW1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_ORDW:
                begin
                    if (left < right)
                    begin
                        if (right > AW'(1))
                        begin
                            stk_lo[sp_reg] <= place_reg + 1'b1;
                            stk_hi[sp_reg] <= hi_reg;
                            sp_reg <= sp_reg + 1'b1;
                        end
                        if (left == '0)
                        begin
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            hi_reg <= place_reg - 1'b1;
                            state_reg <= S_SPLIT;
                        end
                    end
                    else
                    begin
                        if (left > AW'(1))
                        begin
                            stk_lo[sp_reg] <= lo_reg;
                            stk_hi[sp_reg] <= place_reg - 1'b1;
                            sp_reg <= sp_reg + 1'b1;
                        end
                        // pivot at the top of the range: nothing right of it
                        if (right == '0)
                        begin
                            state_reg <= S_POP;
                        end
                        else
                        begin
                            lo_reg <= place_reg + 1'b1;
                            state_reg <= S_SPLIT;
                        end
                    end
                end
                S_RD:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    oitem_reg.sorted_value <= rdata;
                    oitem_reg.last_result <= (oidx_reg + 1'b1 >= count_reg);
                    oitem_reg.overflow <= overflow_reg;
                    if (oidx_reg + 1'b1 >= count_reg)
                    begin
                        count_reg <= '0;
                        overflow_reg <= 1'b0;
                        sp_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule

@@ rtl/qsort_store.sv @@
// Item memory: one write port, one registered read port
module qsort_store
    import qsort_pkg::*;
#(
    parameter int MAX_ITEMS = MaxItemsDefault,
    parameter int WORD_BITS = WordBitsDefault,
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);
    logic [WORD_BITS-1:0] mem [MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/qsort_checker.sv @@
// Port checker for the quicksort array sorter, bound to the top level
`include "quicksort_array_sorter_assert.svh"
module qsort_checker
    import qsort_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);
    `QS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    `QS_ASSERT_IMPL(a_no_overlap, out_valid && !out_item.last_result, !in_ready)
    `QS_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_item.last_result, !out_valid)
    `QS_ASSERT_NEXT(a_mark_stops, in_valid && in_ready && in_item.last_item, !in_ready)
endmodule

bind quicksort_array_sorter qsort_checker u_qsort_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);

@@ verif/quicksort_array_sorter_tb.sv @@
// Testbench for the quicksort array sorter: directed and random sets checked against a sorted prediction
module quicksort_array_sorter_tb
    import qsort_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxItems = 64;
    localparam int RandomItems = 118;
    localparam longint CycleLimit = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    quicksort_array_sorter i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    in_item_t  pending_requests[$];
    out_item_t sorted_expected[$];
    logic [31:0] set_words[$];
    int  set_dropped;
    int  errors;
    int  results_seen;
    int  sets_sent;
    int  overflow_sets;
    longint cycles = 0;
    int  burst_left;
    int  gap_left;
    int  hold_off;
    bit  hold_request;
    bit  pause_sender;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, results_seen);
    endtask

    // sort the accumulated set and queue its burst
    task automatic predict_sorted_burst();
        logic [31:0] words[$];
        words = set_words;
        words.sort();
        foreach (words[k])
        begin
            sorted_expected.push_back('{sorted_value: words[k],
                                        last_result: (k == words.size() - 1),
                                        overflow: (set_dropped != 0)});
        end
        if (set_dropped != 0)
        begin
            overflow_sets++;
        end
        set_words.delete();
        set_dropped = 0;
        sets_sent++;
    endtask

    function automatic logic [31:0] random_word(input int style);
        case (style)
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);
            3: return {1'b1, 31'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_set(input int size, input int style);
        for (int k = 0; k < size; k++)
        begin
            pending_requests.push_back('{value: random_word(style),
                                         last_item: (k == size - 1)});
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            bit fire;
            bit offer;
            fire = in_valid && in_ready;
            if (fire)
            begin
                if (set_words.size() < MaxItems)
                begin
                    set_words.push_back(in_item.value);
                end
                else
                begin
                    set_dropped++;
                end
                if (in_item.last_item)
                begin
                    predict_sorted_burst();
                end
                void'(pending_requests.pop_front());
            end
            offer = 1'b0;
            if (in_valid && !fire)
            begin
                offer = 1'b1;
            end
            else if (pending_requests.size() > 0 && !pause_sender)
            begin
                if (burst_left > 0)
                begin
                    offer = 1'b1;
                    burst_left <= burst_left - 1;
                end
                else if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                end
            end
            in_valid <= offer;
            if (offer && !(in_valid && !fire))
            begin
                in_item <= pending_requests[0];
            end
        end
    end

    // receiver stall pattern and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_item_t want;
                results_seen++;
                if (sorted_expected.size() == 0)
                begin
                    report_mismatch("unexpected result", out_item.sorted_value, 32'h0);
                end
                else
                begin
                    want = sorted_expected.pop_front();
                    if (out_item.sorted_value !== want.sorted_value)
                        report_mismatch("sorted_value", out_item.sorted_value, want.sorted_value);
                    if (out_item.last_result !== want.last_result)
                        report_mismatch("last_result", 32'(out_item.last_result),
                                        32'(want.last_result));
                    if (out_item.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(out_item.overflow),
                                        32'(want.overflow));
                end
            end
            if (hold_request)
            begin
                hold_off <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_off > 0)
            begin
                hold_off  <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= (cycles % 64 < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int n;
        hold_request  = 1'b0;
        pause_sender  = 1'b0;
        rst_n         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single word, pair, extremes, duplicates, top bit set
        pending_requests.push_back('{value: 32'hFFFF_FFFF, last_item: 1'b1});
        pending_requests.push_back('{value: 32'hFFFF_FFFF, last_item: 1'b0});
        pending_requests.push_back('{value: 32'h0, last_item: 1'b1});
        pending_requests.push_back('{value: 32'h8000_0000, last_item: 1'b0});
        pending_requests.push_back('{value: 32'h7FFF_FFFF, last_item: 1'b0});
        pending_requests.push_back('{value: 32'h0000_0001, last_item: 1'b1});
        queue_set(6, 2);
        queue_set(5, 3);
        queue_set(4, 0);

        // sender pause until all results are back
        wait (pending_requests.size() == 0);
        pause_sender = 1'b1;
        wait (sorted_expected.size() == 0 && !in_valid);
        pause_sender = 1'b0;

        // full store, then overflow with the mark on a dropped word
        queue_set(MaxItems, 4);
        queue_set(MaxItems + 3, 4);
        // long receiver hold-off during unload while the sender keeps offering
        wait (out_valid);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;

        n = 0;
        while (n < RandomItems)
        begin
            int size;
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MaxItems)
                                               : $urandom_range(1, 12);
            queue_set(size, $urandom_range(0, 7));
            n += size;
        end

        wait (pending_requests.size() == 0 && !in_valid);
        wait (sorted_expected.size() == 0);
        repeat (200) @(posedge clk);
        $display("sorted %0d sets (%0d with dropped words), %0d results checked",
                 sets_sent, overflow_sets, results_seen);
        if (errors == 0 && sorted_expected.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
